// ===== rtl/core/dtdps_pkg.sv =====
// Shared types and constants for the dual-tap delay-line pitch shifter.
package dtdps_pkg;

   localparam int LINE_DEPTH_DEF    = 2048;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int SAMPLE_W   = 32;
   localparam int PITCH_W    = 17;
   localparam int PITCH_FRAC = 16;
   localparam int FADE_BITS  = 16;
   localparam int WGT_W      = FADE_BITS + 1;

   localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(81920);
   localparam logic [WGT_W-1:0]   FADE_ONE    = WGT_W'(65536);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_A1,
      ST_RD_B1,
      ST_RD_A2,
      ST_RD_B2,
      ST_INTERP2,
      ST_VALUE2,
      ST_WEIGHT,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      MEM_IDLE,
      MEM_CLEAR,
      MEM_SAMPLE,
      MEM_TAP1_A,
      MEM_TAP1_B,
      MEM_TAP2_A,
      MEM_TAP2_B
   } mem_op_type;

   typedef struct packed {
      mem_op_type mem_op;
      logic       cap_d;
      logic       div_load;
      logic       cap_a;
      logic       cap_prod;
      logic       prod_tap2;
      logic       cap_v1;
      logic       cap_v2;
      logic       cap_mix;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/core/dtdps_ctrl.sv =====
// Sequencer for request intake, delay-line accesses, fade and result hand-off.
module dtdps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  dtdps_pkg::status_type status,
   output dtdps_pkg::cmd_type    cmd
);
   import dtdps_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_full;

   assign out_full  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mem_op   = MEM_IDLE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_op = MEM_CLEAR;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.mem_op = MEM_SAMPLE;
               cmd.cap_d  = 1'b1;
               state_in   = ST_RD_A1;
            end
         end
         ST_RD_A1: begin
            cmd.mem_op   = MEM_TAP1_A;
            cmd.div_load = 1'b1;
            state_in     = ST_RD_B1;
         end
         ST_RD_B1: begin
            cmd.mem_op = MEM_TAP1_B;
            cmd.cap_a  = 1'b1;
            state_in   = ST_RD_A2;
         end
         ST_RD_A2: begin
            cmd.mem_op   = MEM_TAP2_A;
            cmd.cap_prod = 1'b1;
            state_in     = ST_RD_B2;
         end
         ST_RD_B2: begin
            cmd.mem_op = MEM_TAP2_B;
            cmd.cap_v1 = 1'b1;
            cmd.cap_a  = 1'b1;
            state_in   = ST_INTERP2;
         end
         ST_INTERP2: begin
            cmd.cap_prod  = 1'b1;
            cmd.prod_tap2 = 1'b1;
            state_in      = ST_VALUE2;
         end
         ST_VALUE2: begin
            cmd.cap_v2 = 1'b1;
            state_in   = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            if (status.div_done) begin
               cmd.cap_mix = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/core/dtdps_datapath.sv =====
// Delay-line memory, tap pointers, interpolation, fade weights and output mix.
module dtdps_datapath #(
   parameter int LINE_DEPTH    = dtdps_pkg::LINE_DEPTH_DEF,
   parameter int FRACTION_BITS = dtdps_pkg::FRACTION_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dtdps_pkg::cmd_type                      cmd,
   output dtdps_pkg::status_type                   status,
   input  logic                                    csr_write,
   input  logic        [dtdps_pkg::PITCH_W-1:0]    csr_pitch_ratio,
   input  logic signed [dtdps_pkg::SAMPLE_W-1:0]   req_in_sample,
   output logic signed [dtdps_pkg::SAMPLE_W-1:0]   rsp_pitched_sample
);
   import dtdps_pkg::*;

   localparam int IDX_W   = $clog2(LINE_DEPTH);
   localparam int POS_W   = IDX_W + FRACTION_BITS;
   localparam int STEP_W  = FRACTION_BITS + 1;
   localparam int DIFF_W  = SAMPLE_W + 1;
   localparam int PROD_W  = FRACTION_BITS + 1 + DIFF_W;
   localparam int VAL_W   = SAMPLE_W + 2;
   localparam int MIX_W   = SAMPLE_W + WGT_W + 1;
   localparam int SUM_W   = MIX_W + 1;
   localparam int QUO_W   = SUM_W - FADE_BITS;
   localparam bit IS_POW2 = ((1 << IDX_W) == LINE_DEPTH);

   localparam logic [POS_W:0]   LINE_SPAN = (POS_W + 1)'(LINE_DEPTH) << FRACTION_BITS;
   localparam logic [POS_W-1:0] HALF_SPAN = POS_W'(LINE_SPAN >> 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LINE_DEPTH - 1);

   function automatic logic [POS_W-1:0] advance_pos(input logic [POS_W-1:0]  pos,
                                                    input logic [STEP_W-1:0] step);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + (POS_W + 1)'(step);
      if (sum >= LINE_SPAN) begin
         sum = sum - LINE_SPAN;
      end
      return sum[POS_W-1:0];
   endfunction

   logic [SAMPLE_W-1:0] mem [LINE_DEPTH];
   logic [SAMPLE_W-1:0] rd_ff;
   logic [IDX_W-1:0]    mem_addr;
   logic                mem_we;
   logic [SAMPLE_W-1:0] mem_wdata;

   logic [IDX_W-1:0]    wr_idx_ff;
   logic [POS_W-1:0]    tap1_ff, tap2_ff;
   logic [PITCH_W-1:0]  pitch_ff;
   logic [POS_W-1:0]    d_ff;

   logic [IDX_W-1:0]    idx1, nxt1, idx2, nxt2;
   logic [PITCH_W+FRACTION_BITS-1:0] pitch_wide;
   logic [STEP_W-1:0]   step;

   logic [POS_W-1:0]    wpos;
   logic [POS_W:0]      d_wide;
   logic [POS_W:0]      rest;
   logic [POS_W-1:0]    m_calc;
   logic [WGT_W-1:0]    w1, w2;
   logic                div_done;

   logic signed [SAMPLE_W-1:0] a_ff;
   logic signed [DIFF_W-1:0]   diff;
   logic [FRACTION_BITS-1:0]   frac;
   logic signed [PROD_W-1:0]   prod_calc, prod_ff;
   logic signed [VAL_W-1:0]    quot, v_calc;
   logic                       fix_v;
   logic signed [SAMPLE_W-1:0] v1_ff, v2_ff;

   logic signed [MIX_W-1:0]    p1_ff, p2_ff;
   logic signed [SUM_W-1:0]    sum;
   logic signed [QUO_W-1:0]    mixq;
   logic                       fix_m;
   logic                       fits;
   logic signed [SAMPLE_W-1:0] sat, out_ff;

   // read addresses of the taps and their neighbors
   always_comb begin
      idx1 = tap1_ff[POS_W-1:FRACTION_BITS];
      idx2 = tap2_ff[POS_W-1:FRACTION_BITS];
      nxt1 = (idx1 == LAST_IDX) ? '0 : idx1 + 1'b1;
      nxt2 = (idx2 == LAST_IDX) ? '0 : idx2 + 1'b1;
   end

   always_comb begin
      mem_addr  = wr_idx_ff;
      mem_we    = 1'b0;
      mem_wdata = '0;
      case (cmd.mem_op)
         MEM_CLEAR: begin
            mem_we = 1'b1;
         end
         MEM_SAMPLE: begin
            mem_we    = 1'b1;
            mem_wdata = req_in_sample;
         end
         MEM_TAP1_A: mem_addr = idx1;
         MEM_TAP1_B: mem_addr = nxt1;
         MEM_TAP2_A: mem_addr = idx2;
         MEM_TAP2_B: mem_addr = nxt2;
         default: mem_addr = wr_idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   assign status.clear_last = (wr_idx_ff == LAST_IDX);
   assign status.div_done   = div_done;

   assign pitch_wide = {pitch_ff, {FRACTION_BITS{1'b0}}};
   assign step       = pitch_wide[PITCH_FRAC+FRACTION_BITS:PITCH_FRAC];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         tap1_ff   <= '0;
         tap2_ff   <= HALF_SPAN;
         pitch_ff  <= PITCH_RESET;
      end else begin
         if (csr_write) begin
            pitch_ff <= csr_pitch_ratio;
         end
         if (cmd.mem_op == MEM_CLEAR || cmd.emit) begin
            wr_idx_ff <= (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         end
         if (cmd.emit) begin
            tap1_ff <= advance_pos(tap1_ff, step);
            tap2_ff <= advance_pos(tap2_ff, step);
         end
      end
   end

   // distance from tap one back to the write pointer
   always_comb begin
      wpos = {wr_idx_ff, {FRACTION_BITS{1'b0}}};
      if (wpos >= tap1_ff) begin
         d_wide = {1'b0, wpos} - {1'b0, tap1_ff};
      end else begin
         d_wide = {1'b0, wpos} + LINE_SPAN - {1'b0, tap1_ff};
      end
      rest   = LINE_SPAN - {1'b0, d_ff};
      m_calc = ({1'b0, d_ff} <= rest) ? d_ff : rest[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_d) begin
         d_ff <= d_wide[POS_W-1:0];
      end
   end

   // tap one weight = floor(2 * min(d, S - d) * 65536 / S)
   generate
      if (IS_POW2) begin : g_shift
         logic [POS_W+FADE_BITS:0] scaled;
         logic [WGT_W-1:0]         w1_ff;
         assign scaled = {m_calc, {WGT_W{1'b0}}};
         always_ff @(posedge clock) begin
            if (cmd.div_load) begin
               w1_ff <= scaled[POS_W+FADE_BITS:POS_W];
            end
         end
         assign w1       = w1_ff;
         assign div_done = 1'b1;
      end else begin : g_recip
         localparam int               XW      = IDX_W + FADE_BITS;
         localparam longint           RECIP_L = (longint'(1) << XW) / longint'(LINE_DEPTH);
         localparam logic [WGT_W-1:0] RECIP   = WGT_W'(RECIP_L);
         localparam logic [XW-1:0]    L_WORDS = XW'(LINE_DEPTH);
         logic [POS_W+WGT_W-1:0] num_wide;
         logic [XW-1:0]          x_val, x_ff, ql, rem_ff;
         logic [XW+WGT_W-1:0]    xr_ff;
         logic [WGT_W-1:0]       q0, q0_ff;
         // (m * 2^17 >> FRACTION_BITS) / LINE_DEPTH: reciprocal estimate, then one fix-up
         assign num_wide = {m_calc, {WGT_W{1'b0}}} >> FRACTION_BITS;
         assign x_val    = num_wide[XW-1:0];
         assign q0       = xr_ff[XW+WGT_W-1:XW];
         assign ql       = XW'(q0) * L_WORDS;
         always_ff @(posedge clock) begin
            if (cmd.div_load) begin
               x_ff  <= x_val;
               xr_ff <= (XW + WGT_W)'(x_val) * (XW + WGT_W)'(RECIP);
            end
            q0_ff  <= q0;
            rem_ff <= x_ff - ql;
         end
         assign w1       = q0_ff + WGT_W'(rem_ff >= L_WORDS);
         assign div_done = 1'b1;
      end
   endgenerate

   assign w2 = FADE_ONE - w1;

   // linear interpolation, one shared multiplier for both taps
   always_comb begin
      diff      = $signed({rd_ff[SAMPLE_W-1], rd_ff}) - $signed({a_ff[SAMPLE_W-1], a_ff});
      frac      = cmd.prod_tap2 ? tap2_ff[FRACTION_BITS-1:0] : tap1_ff[FRACTION_BITS-1:0];
      prod_calc = $signed({1'b0, frac}) * diff;
      quot      = $signed(prod_ff[PROD_W-1:FRACTION_BITS]);
      fix_v     = prod_ff[PROD_W-1] && (|prod_ff[FRACTION_BITS-1:0]);
      v_calc    = $signed({{2{a_ff[SAMPLE_W-1]}}, a_ff}) + quot + $signed({{(VAL_W-1){1'b0}}, fix_v});
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         a_ff <= rd_ff;
      end
      if (cmd.cap_prod) begin
         prod_ff <= prod_calc;
      end
      if (cmd.cap_v1) begin
         v1_ff <= v_calc[SAMPLE_W-1:0];
      end
      if (cmd.cap_v2) begin
         v2_ff <= v_calc[SAMPLE_W-1:0];
      end
      if (cmd.cap_mix) begin
         p1_ff <= v1_ff * $signed({1'b0, w1});
         p2_ff <= v2_ff * $signed({1'b0, w2});
      end
   end

   // crossfade sum, truncate toward zero, clamp
   always_comb begin
      sum   = $signed({p1_ff[MIX_W-1], p1_ff}) + $signed({p2_ff[MIX_W-1], p2_ff});
      fix_m = sum[SUM_W-1] && (|sum[FADE_BITS-1:0]);
      mixq  = $signed(sum[SUM_W-1:FADE_BITS]) + $signed({{(QUO_W-1){1'b0}}, fix_m});
      fits  = (&mixq[QUO_W-1:SAMPLE_W-1]) || !(|mixq[QUO_W-1:SAMPLE_W-1]);
      if (fits) begin
         sat = mixq[SAMPLE_W-1:0];
      end else if (mixq[QUO_W-1]) begin
         sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff <= sat;
      end
   end

   assign rsp_pitched_sample = out_ff;

endmodule

// ===== rtl/core/dual_tap_delay_pitch_shifter_top.sv =====
// Top level of the dual-tap delay-line pitch shifter.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_in_sample       (s32)
//   rsp_      out        rsp_valid / rsp_stall   rsp_pitched_sample  (s32)
//   csr_      in         csr_write               csr_pitch_ratio     (u17, Q1.16)
//
// After reset a clearing pass writes zero to every delay-line word while req_stall
// is high; csr writes are taken throughout.
// From accept until req_stall falls again, a request makes one write and four
// reads on the single-port delay line, then interpolation, weighting and the mix.
// The fade weight is a shift when LINE_DEPTH is a power of two, otherwise a
// reciprocal multiply with one correction; either is ready before the mix uses it.
// The result register lets the next request in while a result waits on rsp_stall.
module dual_tap_delay_pitch_shifter_top #(
   parameter int LINE_DEPTH    = dtdps_pkg::LINE_DEPTH_DEF,
   parameter int FRACTION_BITS = dtdps_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dtdps_pkg::SAMPLE_W-1:0] req_in_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dtdps_pkg::SAMPLE_W-1:0] rsp_pitched_sample,
   input  logic                                  csr_write,
   input  logic        [dtdps_pkg::PITCH_W-1:0]  csr_pitch_ratio
);
   import dtdps_pkg::*;

   cmd_type    cmd;
   status_type status;

   dtdps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dtdps_datapath #(
      .LINE_DEPTH    (LINE_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_pitch_ratio    (csr_pitch_ratio),
      .req_in_sample      (req_in_sample),
      .rsp_pitched_sample (rsp_pitched_sample)
   );

endmodule
